>>> rtl/pf_pkg.sv
// Shared types, constants and the small-prime table for the prime factorization block.
package pf_pkg;

  localparam int unsigned VALUE_W     = 16;
  localparam int unsigned EXP_W       = 5;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned VALUE_BITS_DEFAULT = 16;

  // A 16-bit value has at most six distinct prime factors.
  localparam int unsigned MAX_PAIRS   = 6;
  localparam int unsigned PAIR_IDX_W  = 3;

  // Primes below 256 cover every trial divisor a 16-bit value needs.
  localparam int unsigned PRIME_COUNT = 54;
  localparam int unsigned PRIME_IDX_W = 6;
  localparam int unsigned PRIME_W     = 8;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_LOW  = 2'd1,
    ST_HIGH = 2'd2
  } pf_status_e;

  // One stored result entry: last is derived at read-out.
  typedef struct packed {
    logic [VALUE_W-1:0] prime;
    logic [EXP_W-1:0]   exponent;
    pf_status_e         status;
  } pf_pair_t;

  function automatic logic [PRIME_W-1:0] prime_at(input logic [PRIME_IDX_W-1:0] idx);
    logic [PRIME_W-1:0] p;
    case (idx)
      6'd0:  p = 8'd2;    6'd1:  p = 8'd3;    6'd2:  p = 8'd5;    6'd3:  p = 8'd7;
      6'd4:  p = 8'd11;   6'd5:  p = 8'd13;   6'd6:  p = 8'd17;   6'd7:  p = 8'd19;
      6'd8:  p = 8'd23;   6'd9:  p = 8'd29;   6'd10: p = 8'd31;   6'd11: p = 8'd37;
      6'd12: p = 8'd41;   6'd13: p = 8'd43;   6'd14: p = 8'd47;   6'd15: p = 8'd53;
      6'd16: p = 8'd59;   6'd17: p = 8'd61;   6'd18: p = 8'd67;   6'd19: p = 8'd71;
      6'd20: p = 8'd73;   6'd21: p = 8'd79;   6'd22: p = 8'd83;   6'd23: p = 8'd89;
      6'd24: p = 8'd97;   6'd25: p = 8'd101;  6'd26: p = 8'd103;  6'd27: p = 8'd107;
      6'd28: p = 8'd109;  6'd29: p = 8'd113;  6'd30: p = 8'd127;  6'd31: p = 8'd131;
      6'd32: p = 8'd137;  6'd33: p = 8'd139;  6'd34: p = 8'd149;  6'd35: p = 8'd151;
      6'd36: p = 8'd157;  6'd37: p = 8'd163;  6'd38: p = 8'd167;  6'd39: p = 8'd173;
      6'd40: p = 8'd179;  6'd41: p = 8'd181;  6'd42: p = 8'd191;  6'd43: p = 8'd193;
      6'd44: p = 8'd197;  6'd45: p = 8'd199;  6'd46: p = 8'd211;  6'd47: p = 8'd223;
      6'd48: p = 8'd227;  6'd49: p = 8'd229;  6'd50: p = 8'd233;  6'd51: p = 8'd239;
      6'd52: p = 8'd241;  6'd53: p = 8'd251;
      default: p = 8'd0;
    endcase
    return p;
  endfunction

endpackage

>>> rtl/pf_in_if.sv
// Input channel: one value to factor per transfer.
interface pf_in_if;
  logic                        valid;
  logic                        ready;
  logic [pf_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

>>> rtl/pf_out_if.sv
// Output channel: one (prime, exponent) pair or error result per transfer.
interface pf_out_if;
  logic                         valid;
  logic                         ready;
  logic [pf_pkg::VALUE_W-1:0]   prime;
  logic [pf_pkg::EXP_W-1:0]     exponent;
  logic [pf_pkg::STATUS_W-1:0]  status;
  logic                         last;

  modport source (output valid, output prime, output exponent, output status,
                  output last, input ready);
  modport sink   (input valid, input prime, input exponent, input status,
                  input last, output ready);
endinterface

>>> rtl/prime_factorization.sv
// Prime factorization by trial division over a small-prime table with a result memory.
//
// Usage:
//   in_ch carries one unsigned value per transfer; out_ch returns its factorization
//   as (prime, exponent) pairs in ascending prime order, last set on the final pair.
//   A value below two gives one result with status 1; a value above value_limit
//   gives one result with status 2. Both error results have prime and exponent zero.
//   value_limit is written through cfg_we_i / cfg_data_i while the block is idle.
//   One value is worked on at a time: in_ch.ready is high only when idle.
// Operation:
//   Each trial prime costs a compare state (S_CHECK) plus a bit-serial division
//   (S_DIV), and each further division by the same prime another division. Each
//   result needs a memory read state (S_READ) and an output state (S_SEND); the
//   next value is taken only after the last result has been sent.
// Reset:
//   The controller returns to idle and value_limit goes to 65535. The result memory
//   is not cleared; only entries written for the current value are read.
// Stalls:
//   A result stays in the output register until out_ch.ready takes it.
module prime_factorization
  import pf_pkg::*;
#(
  parameter int unsigned VALUE_BITS = pf_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pf_pkg::VALUE_W-1:0]   cfg_data_i,
  pf_in_if.sink                        in_ch,
  pf_out_if.source                     out_ch
);

  // Input mask for narrow configurations.
  localparam logic [31:0] MaskWide = (VALUE_BITS >= 32) ? 32'hFFFF_FFFF
                                                        : ((32'd1 << VALUE_BITS) - 32'd1);
  localparam logic [VALUE_W-1:0] ValueMask = MaskWide[VALUE_W-1:0];

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_DIV    = 6'b000100,
    S_FINISH = 6'b001000,
    S_READ   = 6'b010000,
    S_SEND   = 6'b100000
  } pf_state_e;

  pf_state_e               state_q, state_d;
  logic [VALUE_W-1:0]      limit_q;
  logic [VALUE_W-1:0]      n_q, n_d;
  logic [VALUE_W-1:0]      quo_q, quo_d;
  logic [PRIME_W:0]        rem_q, rem_d;
  logic [PRIME_W-1:0]      d_q, d_d;
  logic [3:0]              step_q, step_d;
  logic [EXP_W-1:0]        exp_q, exp_d;
  logic [PRIME_IDX_W-1:0]  pidx_q, pidx_d;
  logic [PAIR_IDX_W-1:0]   cnt_q, cnt_d;
  logic [PAIR_IDX_W-1:0]   rd_idx_q, rd_idx_d;

  // Result memory: one write port, one registered read port.
  pf_pair_t                mem [MAX_PAIRS];
  pf_pair_t                rd_data_q;
  logic                    mem_we;
  logic [PAIR_IDX_W-1:0]   mem_waddr;
  pf_pair_t                mem_wdata;

  logic [VALUE_W-1:0]      in_value;
  logic [PRIME_W-1:0]      cur_prime;
  logic [VALUE_W-1:0]      cur_sq;
  logic [PRIME_W:0]        trial;
  logic [PRIME_W:0]        trial_diff;
  logic                    trial_ge;
  logic                    in_xfer;
  logic                    out_xfer;
  logic                    out_last;

  assign in_ch.ready = (state_q == S_IDLE);
  assign in_xfer     = in_ch.valid & in_ch.ready;
  assign out_xfer    = out_ch.valid & out_ch.ready;
  assign in_value    = in_ch.value & ValueMask;

  // Candidate prime and its square for the loop-end test.
  assign cur_prime = prime_at(pidx_q);
  assign cur_sq    = VALUE_W'(cur_prime) * VALUE_W'(cur_prime);

  // One restoring-division step.
  assign trial      = {rem_q[PRIME_W-1:0], quo_q[VALUE_W-1]};
  assign trial_ge   = (trial >= {1'b0, d_q});
  assign trial_diff = trial - {1'b0, d_q};

  // Output register is the memory read data.
  assign out_last        = (rd_idx_q == (cnt_q - PAIR_IDX_W'(1)));
  assign out_ch.valid    = (state_q == S_SEND);
  assign out_ch.prime    = rd_data_q.prime;
  assign out_ch.exponent = rd_data_q.exponent;
  assign out_ch.status   = rd_data_q.status;
  assign out_ch.last     = out_last;

  // Controller and datapath next state.
  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    d_d       = d_q;
    step_d    = step_q;
    exp_d     = exp_q;
    pidx_d    = pidx_q;
    cnt_d     = cnt_q;
    rd_idx_d  = rd_idx_q;
    mem_we    = 1'b0;
    mem_waddr = cnt_q;
    mem_wdata = '{prime: '0, exponent: '0, status: ST_OK};

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          rd_idx_d = '0;
          if (in_value < VALUE_W'(2)) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = '{prime: '0, exponent: '0, status: ST_LOW};
            cnt_d     = PAIR_IDX_W'(1);
            state_d   = S_READ;
          end else if (in_value > limit_q) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = '{prime: '0, exponent: '0, status: ST_HIGH};
            cnt_d     = PAIR_IDX_W'(1);
            state_d   = S_READ;
          end else begin
            n_d     = in_value;
            cnt_d   = '0;
            pidx_d  = '0;
            state_d = S_CHECK;
          end
        end
      end

      S_CHECK: begin
        if ((pidx_q == PRIME_IDX_W'(PRIME_COUNT)) || (cur_sq > n_q) ||
            (cnt_q == PAIR_IDX_W'(MAX_PAIRS))) begin
          state_d = S_FINISH;
        end else begin
          d_d     = cur_prime;
          quo_d   = n_q;
          rem_d   = '0;
          step_d  = '0;
          exp_d   = '0;
          state_d = S_DIV;
        end
      end

      S_DIV: begin
        rem_d  = trial_ge ? trial_diff : trial;
        quo_d  = {quo_q[VALUE_W-2:0], trial_ge};
        step_d = step_q + 4'd1;
        if (step_q == 4'd15) begin
          if (rem_d == '0) begin
            // Divides evenly: keep the quotient and try the same prime again.
            n_d   = quo_d;
            exp_d = exp_q + EXP_W'(1);
          end else begin
            if (exp_q != '0) begin
              mem_we    = 1'b1;
              mem_wdata = '{prime: VALUE_W'(d_q), exponent: exp_q, status: ST_OK};
              cnt_d     = cnt_q + PAIR_IDX_W'(1);
            end
            pidx_d  = pidx_q + PRIME_IDX_W'(1);
            state_d = S_CHECK;
          end
        end
      end

      S_FINISH: begin
        // Whatever is left above one is itself prime.
        if ((n_q > VALUE_W'(1)) && (cnt_q < PAIR_IDX_W'(MAX_PAIRS))) begin
          mem_we    = 1'b1;
          mem_wdata = '{prime: n_q, exponent: EXP_W'(1), status: ST_OK};
          cnt_d     = cnt_q + PAIR_IDX_W'(1);
        end
        rd_idx_d = '0;
        state_d  = S_READ;
      end

      S_READ: begin
        state_d = S_SEND;
      end

      S_SEND: begin
        if (out_xfer) begin
          if (out_last) begin
            state_d = S_IDLE;
          end else begin
            rd_idx_d = rd_idx_q + PAIR_IDX_W'(1);
            state_d  = S_READ;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      limit_q  <= '1;
      cnt_q    <= '0;
      rd_idx_q <= '0;
      pidx_q   <= '0;
      step_q   <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_idx_q <= rd_idx_d;
      pidx_q   <= pidx_d;
      step_q   <= step_d;
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    d_q   <= d_d;
    exp_q <= exp_d;
  end

  // Result memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[rd_idx_q];
  end

  // Checks.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= PAIR_IDX_W'(MAX_PAIRS))
    else $error("result count beyond memory depth");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> (rd_idx_q < cnt_q))
    else $error("result read past the written entries");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) && (step_q != 4'd0) |-> (rem_q < {1'b0, d_q}))
    else $error("partial remainder not below divisor");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ch.ready && out_ch.valid))
    else $error("input taken while a result is pending");

  a_exp_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> ((out_ch.status == ST_OK) == (out_ch.exponent != '0)))
    else $error("exponent and status disagree");

endmodule

>>> tb/sv/prime_factorization_tb.sv
// Self-checking testbench for the prime factorization block: directed, limit, back-pressure and random runs.
module prime_factorization_tb;
  import pf_pkg::*;

  localparam int unsigned VALUE_BITS    = 16;
  localparam int unsigned CLK_HALF      = 2;
  localparam int unsigned RESET_CYCLES  = 11;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned LIMIT_CYCLES  = 1500000;
  localparam int unsigned VALUE_MAX     = 65535;

  // One expected output transfer
  typedef struct {
    logic [VALUE_W-1:0] prime;
    logic [EXP_W-1:0]   exponent;
    pf_status_e         status;
    logic               last;
  } factor_pair_t;

  logic               clk_i    = 1'b0;
  logic               rst_ni   = 1'b0;
  logic               cfg_we   = 1'b0;
  logic [VALUE_W-1:0] cfg_data = '0;
  logic               hold_start = 1'b0;

  pf_in_if  in_ch ();
  pf_out_if out_ch ();

  prime_factorization #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  factor_pair_t factor_queue [$];
  int unsigned  limit_now    = VALUE_MAX;  // predictor's copy of value_limit
  int unsigned  src_idle_pct = 0;
  int unsigned  rcv_idle_pct = 0;
  int unsigned  hold_left    = 0;
  int unsigned  values_sent  = 0;
  int unsigned  results_seen = 0;
  int unsigned  limit_writes = 0;
  int unsigned  mismatches   = 0;

  // Clock
  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("Timeout with %0d results outstanding", factor_queue.size());
    $display("Mismatches found");
    $finish;
  end

  // Expected pairs for one accepted value, by trial division
  function automatic void predict_factors(input logic [VALUE_W-1:0] raw);
    longint unsigned mask;
    int unsigned     n;
    int unsigned     d;
    int unsigned     e;
    int unsigned     count;
    factor_pair_t    pair;
    mask = (64'd1 << VALUE_BITS) - 1;
    n = int'(raw & mask);
    pair.prime    = '0;
    pair.exponent = '0;
    pair.last     = 1'b1;
    if (n < 2) begin
      pair.status = ST_LOW;
      factor_queue.push_back(pair);
      return;
    end
    if (n > limit_now) begin
      pair.status = ST_HIGH;
      factor_queue.push_back(pair);
      return;
    end
    pair.status = ST_OK;
    pair.last   = 1'b0;
    count = 0;
    for (d = 2; d * d <= n && count < MAX_PAIRS; d++) begin
      e = 0;
      while (n % d == 0) begin
        n = n / d;
        e++;
      end
      if (e != 0) begin
        pair.prime    = VALUE_W'(d);
        pair.exponent = EXP_W'(e);
        factor_queue.push_back(pair);
        count++;
      end
    end
    if (n > 1 && count < MAX_PAIRS) begin
      pair.prime    = VALUE_W'(n);
      pair.exponent = EXP_W'(1);
      factor_queue.push_back(pair);
    end
    // last flag goes on the final pair of the run
    pair = factor_queue.pop_back();
    pair.last = 1'b1;
    factor_queue.push_back(pair);
  endfunction

  // Compare one output transfer with the oldest expected pair
  function automatic void check_result();
    factor_pair_t want;
    if (factor_queue.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("Unexpected result: prime %0d exponent %0d status %0d last %0b",
                 out_ch.prime, out_ch.exponent, out_ch.status, out_ch.last);
      return;
    end
    want = factor_queue.pop_front();
    results_seen++;
    if (out_ch.prime !== want.prime || out_ch.exponent !== want.exponent ||
        out_ch.status !== want.status || out_ch.last !== want.last) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("Result %0d: want prime %0d exp %0d status %0d last %0b, got %0d %0d %0d %0b",
                 results_seen, want.prime, want.exponent, want.status, want.last,
                 out_ch.prime, out_ch.exponent, out_ch.status, out_ch.last);
    end
  endfunction

  // Result side: check on each transfer, then pick next ready
  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) check_result();
    out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= rcv_idle_pct);
  end

  // Long receiver hold-off counter
  always @(posedge clk_i) begin
    if (hold_start) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Offer one value and wait for its transfer
  task automatic send_value(input logic [VALUE_W-1:0] v);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_factors(v);
    values_sent++;
  endtask

  // Stop offering and wait until every expected pair has come out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (factor_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write value_limit while the block is idle
  task automatic set_limit(input logic [VALUE_W-1:0] lim);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= lim;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    limit_now = 32'(lim);
    limit_writes++;
  endtask

  // Random value: mostly small or smooth numbers, some full range and near the top
  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned kind;
    int unsigned prod;
    int unsigned p;
    kind = $urandom_range(99);
    if (kind < 5) return VALUE_W'($urandom_range(1));
    if (kind < 30) return VALUE_W'($urandom_range(1023));
    if (kind < 50) return VALUE_W'($urandom_range(VALUE_MAX));
    if (kind < 80) begin
      // product of small primes, many pairs per value
      prod = 1;
      repeat ($urandom_range(12, 2)) begin
        p = 32'(prime_at(PRIME_IDX_W'($urandom_range(15))));
        if (prod * p <= VALUE_MAX) prod = prod * p;
      end
      return VALUE_W'(prod);
    end
    if (kind < 92) begin
      // power of one table prime
      p = 32'(prime_at(PRIME_IDX_W'($urandom_range(PRIME_COUNT - 1))));
      prod = p;
      while (prod * p <= VALUE_MAX && $urandom_range(3) != 0) prod = prod * p;
      return VALUE_W'(prod);
    end
    return VALUE_W'(VALUE_MAX - $urandom_range(255));
  endfunction

  // Field extremes, six-prime values, prime powers and large remainders
  task automatic test_directed();
    logic [VALUE_W-1:0] vals [$];
    vals = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd6, 16'd49, 16'd256,
             16'd30030, 16'd46410, 16'd32768, 16'd63001, 16'd64507, 16'd65521,
             16'd65534, 16'hFFFF, 16'hAAAA, 16'h5555, 16'd65025, 16'd9973};
    set_limit(VALUE_W'(VALUE_MAX));
    foreach (vals[i]) send_value(vals[i]);
    wait_drained();
  endtask

  // Limit register at its extremes and around the boundary
  task automatic test_limits();
    set_limit(16'd0);
    send_value(16'd0);
    send_value(16'd1);
    send_value(16'd2);
    send_value(16'hFFFF);
    set_limit(16'd1000);
    send_value(16'd999);
    send_value(16'd1000);
    send_value(16'd1001);
    set_limit(16'd2);
    send_value(16'd2);
    send_value(16'd3);
    send_value(16'd1);
    set_limit(VALUE_W'(VALUE_MAX));
    send_value(16'hFFFF);
    wait_drained();
  endtask

  // Receiver holds off while values keep coming, so the block stalls its input
  task automatic test_backpressure();
    hold_start <= 1'b1;
    @(posedge clk_i);
    hold_start <= 1'b0;
    send_value(16'd30030);
    send_value(16'd12);
    send_value(16'd1);
    send_value(16'd64);
    send_value(16'd210);
    send_value(16'hFFFF);
    wait_drained();
  endtask

  task automatic test_random(input int unsigned count, input logic [VALUE_W-1:0] lim);
    set_limit(lim);
    repeat (count) send_value(pick_value());
    wait_drained();
  endtask

  // Test sequence
  initial begin
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 19;
    rcv_idle_pct = 56;
    test_directed();
    test_limits();
    test_random(64, VALUE_W'(VALUE_MAX));

    src_idle_pct = 56;
    rcv_idle_pct = 19;
    test_backpressure();
    test_random(64, VALUE_W'($urandom_range(65534, 20000)));

    src_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random(64, VALUE_W'($urandom_range(VALUE_MAX, 1000)));

    wait_drained();
    $display("Factored %0d values into %0d checked results over %0d limit settings",
             values_sent, results_seen, limit_writes);
    $display("Idle mixes: sender-light, receiver-light, none; one long receiver hold-off");
    if (mismatches == 0 && factor_queue.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> prime_factorization.f
rtl/pf_pkg.sv
rtl/pf_in_if.sv
rtl/pf_out_if.sv
rtl/prime_factorization.sv
tb/sv/prime_factorization_tb.sv
